// ----- hw/rtl/etok_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_pkg: shared types and constants of the expression tokenizer
// Token codes, scan modes, character constants and byte classifiers.
// ----------------------------------------------------------------------------
package etok_pkg;

  localparam int START_W = 16;
  localparam int LEN_W   = 16;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_POINT = 8'h2E;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_INT   = 3'd1,
    MODE_FRAC  = 3'd2,
    MODE_IDENT = 3'd3,
    MODE_EQ    = 3'd4
  } scan_mode_t;

  typedef enum logic [2:0] {
    TOK_NUMBER = 3'd0,
    TOK_IDENT  = 3'd1,
    TOK_COMMA  = 3'd2,
    TOK_OPEN   = 3'd3,
    TOK_CLOSE  = 3'd4,
    TOK_DERIVE = 3'd5
  } tok_type_t;

  typedef struct packed {
    logic              last;
    logic [LEN_W-1:0]  length;
    logic [START_W-1:0] start;
    tok_type_t         kind;
  } tok_t;

  // tokens produced by one byte, in order; count is 0, 1 or 2
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok1;
    tok_t       tok0;
  } tok_push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

endpackage

// ----- hw/rtl/etok_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_scan: scan state and per-byte token decode
// Holds mode, position and the token in progress; decodes each accepted
// byte into zero, one or two tokens in the same cycle.
// ----------------------------------------------------------------------------
module etok_scan #(
  parameter int POS_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic [7:0]          ch,
  input  logic                is_last,
  output etok_pkg::tok_push_t push
);
  import etok_pkg::*;

  scan_mode_t           mode, mode_next, mode_mid;
  logic [POS_WIDTH-1:0] position, position_next;
  logic [START_W-1:0]   pending_start, pending_start_next, start_mid;
  logic [LEN_W-1:0]     pending_length, pending_length_next, len_mid, len_grow;
  logic [31:0]          pos_wide;
  logic [START_W-1:0]   here;
  logic                 dig, let_c, idle_path;
  logic                 a_valid, b_valid, c_valid;
  tok_t                 tok_a, tok_b, tok_c;

  assign pos_wide = 32'(position);
  assign here     = pos_wide[START_W-1:0];
  assign dig      = is_digit(ch);
  assign let_c    = is_letter(ch);
  assign len_grow = (pending_length != LEN_MAX) ? pending_length + LEN_W'(1) : pending_length;

  // next state
  always_comb begin
    mode_mid  = mode;
    start_mid = pending_start;
    len_mid   = pending_length;
    idle_path = 1'b0;
    unique case (mode)
      MODE_INT: begin
        if (dig) begin
          len_mid = len_grow;
        end else if (ch == CH_POINT) begin
          len_mid  = len_grow;
          mode_mid = MODE_FRAC;
        end else begin
          idle_path = 1'b1;
        end
      end
      MODE_FRAC: begin
        if (dig) len_mid = len_grow;
        else     idle_path = 1'b1;
      end
      MODE_IDENT: begin
        if (let_c) len_mid = len_grow;
        else       idle_path = 1'b1;
      end
      MODE_EQ: begin
        if (ch == CH_GT) mode_mid = MODE_IDLE;
        else             idle_path = 1'b1;
      end
      default: begin
        idle_path = 1'b1;
      end
    endcase
    if (idle_path) begin
      mode_mid = MODE_IDLE;
      if (ch == CH_EQ || dig || ch == CH_POINT || let_c) begin
        start_mid = here;
        len_mid   = LEN_W'(1);
        if (ch == CH_EQ)         mode_mid = MODE_EQ;
        else if (dig)            mode_mid = MODE_INT;
        else if (ch == CH_POINT) mode_mid = MODE_FRAC;
        else                     mode_mid = MODE_IDENT;
      end
    end

    if (is_last) begin
      mode_next           = MODE_IDLE;
      position_next       = '0;
      pending_start_next  = '0;
      pending_length_next = '0;
    end else begin
      mode_next           = mode_mid;
      position_next       = position + POS_WIDTH'(1);
      pending_start_next  = start_mid;
      pending_length_next = len_mid;
    end
  end

  // token outputs
  always_comb begin
    // token that ends what was pending, or a completed derive
    a_valid      = 1'b0;
    tok_a.kind   = TOK_NUMBER;
    tok_a.start  = pending_start;
    tok_a.length = pending_length;
    tok_a.last   = 1'b0;
    unique case (mode)
      MODE_INT, MODE_FRAC: a_valid = idle_path;
      MODE_IDENT: begin
        a_valid    = idle_path;
        tok_a.kind = TOK_IDENT;
      end
      MODE_EQ: begin
        a_valid      = (ch == CH_GT);
        tok_a.kind   = TOK_DERIVE;
        tok_a.length = LEN_W'(2);
      end
      default: a_valid = 1'b0;
    endcase

    // single-character token
    b_valid      = idle_path && (ch == CH_COMMA || ch == CH_OPEN || ch == CH_CLOSE);
    tok_b.kind   = (ch == CH_COMMA) ? TOK_COMMA : (ch == CH_OPEN) ? TOK_OPEN : TOK_CLOSE;
    tok_b.start  = here;
    tok_b.length = LEN_W'(1);
    tok_b.last   = 1'b0;

    // flush at end of stream
    c_valid      = is_last && (mode_mid == MODE_INT || mode_mid == MODE_FRAC ||
                               mode_mid == MODE_IDENT);
    tok_c.kind   = (mode_mid == MODE_IDENT) ? TOK_IDENT : TOK_NUMBER;
    tok_c.start  = start_mid;
    tok_c.length = len_mid;
    tok_c.last   = 1'b0;

    // b and c never both fire: b leaves the mode idle, c needs a pending token
    push.tok1      = c_valid ? tok_c : tok_b;
    push.tok1.last = 1'b1;
    if (a_valid) begin
      push.tok0      = tok_a;
      push.tok0.last = !(b_valid || c_valid);
      push.count     = (b_valid || c_valid) ? 2'd2 : 2'd1;
    end else begin
      push.tok0      = push.tok1;
      push.count     = (b_valid || c_valid) ? 2'd1 : 2'd0;
    end
    if (!in_fire) push.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      position       <= '0;
      pending_start  <= '0;
      pending_length <= '0;
    end else if (in_fire) begin
      mode           <= mode_next;
      position       <= position_next;
      pending_start  <= pending_start_next;
      pending_length <= pending_length_next;
    end
  end

  a_last_resets_pos: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_last |=> position == '0 && mode == MODE_IDLE)
    else $error("position not cleared after last byte");

  a_two_need_end: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> a_valid && (mode != MODE_IDLE))
    else $error("two tokens without an ending token");

  a_pending_len: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_INT || mode == MODE_FRAC || mode == MODE_IDENT) |->
      pending_length != '0)
    else $error("pending token with zero length");

endmodule

// ----- hw/rtl/etok_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etok_fifo: token output queue
// Four-entry register queue, up to two writes and one read per cycle.
// ----------------------------------------------------------------------------
module etok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  etok_pkg::tok_push_t push,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_ready,
  output etok_pkg::tok_t      out_tok
);
  import etok_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = 2;
  localparam int CNT_W = 3;

  tok_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign out_valid  = (count != '0);
  assign out_tok    = entries[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign room2      = (count <= CNT_W'(DEPTH - 2));
  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.tok0;
    if (push.count == 2'd2) entries[wr_ptr + PTR_W'(1)] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> 32'(count) + 32'(push.count) <= DEPTH)
    else $error("token queue overflow");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == $past(count) + CNT_W'($past(push.count)) - CNT_W'($past(pop)))
    else $error("queue count out of step");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count != CNT_W'(DEPTH) |-> PTR_W'(wr_ptr - rd_ptr) == count[PTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule

// ----- hw/rtl/expression_tokenizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expression_tokenizer_top: streaming expression tokenizer
// Bytes in on the slave stream, tokens out on the master stream.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while s_axis_tready is high. Each byte is
// decoded in the cycle it is transferred and yields zero, one or two
// tokens, which go into a four-entry output queue; the output stream
// drains one token per cycle while m_axis_tready is high. s_axis_tready
// is high while the queue has room for two tokens, so bytes flow at one
// per cycle as long as the output keeps up; bytes that end one token and
// produce another put two tokens in the queue, and a long run of those is
// limited by the one-token-per-cycle output. A byte with s_axis_tlast set
// flushes any number or identifier in progress and restarts the position
// count at zero; the last token caused by a byte carries m_axis_tlast.
module expression_tokenizer_top #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [2:0] token_type, [18:3] token_start,
                                      // [34:19] token_length, [39:35] zero
  output logic        m_axis_tlast    // last_of_run
);
  import etok_pkg::*;

  tok_push_t push;
  tok_t      out_tok;
  logic      room2;
  logic      in_fire;

  assign s_axis_tready = room2;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  etok_scan #(
    .POS_WIDTH(POS_WIDTH)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .ch      (s_axis_tdata),
    .is_last (s_axis_tlast),
    .push    (push)
  );

  etok_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_tok   (out_tok)
  );

  assign m_axis_tdata = {5'd0, out_tok.length, out_tok.start, out_tok.kind};
  assign m_axis_tlast = out_tok.last;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the expression tokenizer
// Drives byte streams with random gaps and output back-pressure. A behavioral
// tokenizer in the bench predicts each token not given in a typed row, and
// each output transfer is compared field by field against the oldest one due.
// ----------------------------------------------------------------------------
module tb;
  import etok_pkg::*;

  localparam int POS_W       = 16;
  localparam int TARGET      = 1250;   // bytes in the random part
  localparam int HOLD_CYCLES = 200;    // long output stall
  localparam int IDLE_LIMIT  = 2000;   // cycles with no transfer on either side
  localparam int LONG_RUN    = 24;     // identifier run in the last part
  localparam int DRAIN       = 20;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  expression_tokenizer_top #(
    .POS_WIDTH(POS_W)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // bench copy of the scanner state
  scan_mode_t       sc_mode;
  logic [POS_W-1:0] sc_pos;
  logic [15:0]      tok_begin;
  logic [15:0]      tok_len;

  tok_t new_tokens[$];   // tokens caused by the byte just transferred
  tok_t due_tokens[$];   // tokens still to come out of the block

  int  errors;
  int  idle_cycles;
  bit  jitter_on;
  bit  hold_req;

  typedef struct {
    logic [7:0]  c;
    logic        fin;
    bit          typed;     // expectation written in the row
    bit          has_tok;
    tok_type_t   kind;
    logic [15:0] start;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit digit_ch(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit letter_ch(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic void add_token(input tok_type_t k, input logic [15:0] s,
                                    input logic [15:0] l);
    tok_t t;
    t.kind   = k;
    t.start  = s;
    t.length = l;
    t.last   = 1'b0;
    if (new_tokens.size() < 2) new_tokens.push_back(t);
  endfunction

  function automatic void grow_len();
    if (tok_len != LEN_MAX) tok_len = tok_len + 16'd1;
  endfunction

  function automatic void open_token(input scan_mode_t m, input logic [15:0] here);
    sc_mode   = m;
    tok_begin = here;
    tok_len   = 16'd1;
  endfunction

  function automatic void scan_from_idle(input logic [7:0] c, input logic [15:0] here);
    sc_mode = MODE_IDLE;
    if (c == CH_COMMA)      add_token(TOK_COMMA, here, 16'd1);
    else if (c == CH_OPEN)  add_token(TOK_OPEN, here, 16'd1);
    else if (c == CH_CLOSE) add_token(TOK_CLOSE, here, 16'd1);
    else if (c == CH_EQ)    open_token(MODE_EQ, here);
    else if (digit_ch(c))   open_token(MODE_INT, here);
    else if (c == CH_POINT) open_token(MODE_FRAC, here);
    else if (letter_ch(c))  open_token(MODE_IDENT, here);
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
    logic [15:0] here;
    tok_t t;
    here = sc_pos[15:0];
    new_tokens.delete();
    case (sc_mode)
      MODE_INT: begin
        if (digit_ch(c)) begin
          grow_len();
        end else if (c == CH_POINT) begin
          grow_len();
          sc_mode = MODE_FRAC;
        end else begin
          add_token(TOK_NUMBER, tok_begin, tok_len);
          scan_from_idle(c, here);
        end
      end
      MODE_FRAC: begin
        if (digit_ch(c)) begin
          grow_len();
        end else begin
          add_token(TOK_NUMBER, tok_begin, tok_len);
          scan_from_idle(c, here);
        end
      end
      MODE_IDENT: begin
        if (letter_ch(c)) begin
          grow_len();
        end else begin
          add_token(TOK_IDENT, tok_begin, tok_len);
          scan_from_idle(c, here);
        end
      end
      MODE_EQ: begin
        if (c == CH_GT) begin
          add_token(TOK_DERIVE, tok_begin, 16'd2);
          sc_mode = MODE_IDLE;
        end else begin
          scan_from_idle(c, here);
        end
      end
      default: scan_from_idle(c, here);
    endcase
    sc_pos = sc_pos + POS_W'(1);
    if (fin) begin
      if (sc_mode == MODE_INT || sc_mode == MODE_FRAC)
        add_token(TOK_NUMBER, tok_begin, tok_len);
      else if (sc_mode == MODE_IDENT)
        add_token(TOK_IDENT, tok_begin, tok_len);
      sc_mode   = MODE_IDLE;
      sc_pos    = '0;
      tok_begin = '0;
      tok_len   = '0;
    end
    if (new_tokens.size() > 0) begin
      t = new_tokens.pop_back();
      t.last = 1'b1;
      new_tokens.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic send_byte(input logic [7:0] c, input logic fin, input bit predict);
    int gap;
    if (jitter_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tokenize_byte(c, fin);
    if (predict) begin
      foreach (new_tokens[i]) due_tokens.push_back(new_tokens[i]);
    end
  endtask

  task automatic add_row(input logic [7:0] c, input logic fin, input bit typed,
                         input bit has_tok, input tok_type_t kind,
                         input logic [15:0] start);
    dir_row_t r;
    r.c       = c;
    r.fin     = fin;
    r.typed   = typed;
    r.has_tok = has_tok;
    r.kind    = kind;
    r.start   = start;
    dir_rows.push_back(r);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return CH_UP_A + 8'($urandom_range(0, 25));
    return CH_LO_A + 8'($urandom_range(0, 25));
  endfunction

  // one lexical piece of an expression; returns how many bytes were sent
  task automatic send_fragment(output int counted);
    logic [7:0] frag[$];
    int   k;
    int   n;
    logic fin;
    k = $urandom_range(0, 19);
    if (k < 5) begin
      if ($urandom_range(0, 4) == 0) begin
        frag.push_back(CH_POINT);
        n = $urandom_range(1, 4);
        repeat (n) frag.push_back(rand_digit());
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) frag.push_back(rand_digit());
        if ($urandom_range(0, 1) == 1) begin
          frag.push_back(CH_POINT);
          n = $urandom_range(0, 4);
          repeat (n) frag.push_back(rand_digit());
        end
      end
    end else if (k < 9) begin
      n = $urandom_range(1, 8);
      repeat (n) frag.push_back(rand_letter());
    end else if (k == 9) begin
      frag.push_back(CH_COMMA);
    end else if (k == 10) begin
      frag.push_back(CH_OPEN);
    end else if (k == 11) begin
      frag.push_back(CH_CLOSE);
    end else if (k < 14) begin
      frag.push_back(CH_EQ);
      frag.push_back(CH_GT);
    end else if (k == 14) begin
      frag.push_back(CH_EQ);     // lone '=', dropped by what follows
    end else if (k < 18) begin
      case ($urandom_range(0, 3))
        0:       frag.push_back(CH_SPACE);
        1:       frag.push_back(CH_TAB);
        2:       frag.push_back(CH_CR);
        default: frag.push_back(CH_LF);
      endcase
    end else begin
      frag.push_back(8'($urandom_range(0, 255)));
    end
    fin = ($urandom_range(0, 11) == 0);
    foreach (frag[i]) send_byte(frag[i], fin && (i == frag.size() - 1), 1'b1);
    counted = frag.size();
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    int items;
    int got;
    int next_mix;
    bit held;
    bit paused;
    tok_t t;

    errors        = 0;
    jitter_on     = 1'b1;
    hold_req      = 1'b0;
    sc_mode       = MODE_IDLE;
    sc_pos        = '0;
    tok_begin     = '0;
    tok_len       = '0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part: typed rows hold what is obvious right after reset
    add_row(CH_COMMA, 1'b0, 1, 1, TOK_COMMA, 16'd0);
    add_row(CH_OPEN,  1'b0, 1, 1, TOK_OPEN,  16'd1);
    add_row(CH_CLOSE, 1'b0, 1, 1, TOK_CLOSE, 16'd2);
    add_row(8'hFF,    1'b0, 1, 0, TOK_NUMBER, 16'd0);  // top byte skipped
    add_row(8'h00,    1'b0, 1, 0, TOK_NUMBER, 16'd0);
    add_row(CH_ZERO + 8'd1, 1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_ZERO + 8'd2, 1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_POINT,       1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_ZERO + 8'd5, 1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_POINT,       1'b0, 0, 0, TOK_NUMBER, 16'd0);  // second point
    add_row(CH_LO_A,        1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_UP_Z,        1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_COMMA,       1'b0, 0, 0, TOK_NUMBER, 16'd0);  // two tokens
    add_row(CH_EQ,          1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_GT,          1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_EQ,          1'b0, 0, 0, TOK_NUMBER, 16'd0);  // lone '='
    add_row(CH_LO_Z - 8'd2, 1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_SPACE,       1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_TAB,         1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_LF,          1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_CR,          1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_EQ,          1'b1, 1, 0, TOK_NUMBER, 16'd0);  // '=' at end dropped
    add_row(CH_ZERO + 8'd7, 1'b1, 1, 1, TOK_NUMBER, 16'd0);
    add_row(CH_LO_A + 8'd16, 1'b0, 0, 0, TOK_NUMBER, 16'd0);
    add_row(CH_CLOSE,       1'b1, 0, 0, TOK_NUMBER, 16'd0);  // identifier and paren at end
    add_row(CH_POINT,       1'b1, 0, 0, TOK_NUMBER, 16'd0);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].c, dir_rows[i].fin, !dir_rows[i].typed);
      if (dir_rows[i].typed && dir_rows[i].has_tok) begin
        t.kind   = dir_rows[i].kind;
        t.start  = dir_rows[i].start;
        t.length = 16'd1;
        t.last   = 1'b1;
        due_tokens.push_back(t);
      end
    end

    // random expressions
    items    = 0;
    next_mix = 0;
    held     = 0;
    paused   = 0;
    while (items < TARGET) begin
      if (items >= next_mix) begin
        jitter_on = ($urandom_range(0, 3) != 0);
        next_mix  = next_mix + 150;
      end
      if (!held && items >= 400) begin
        hold_req = 1'b1;
        held     = 1;
      end
      if (!paused && items >= 800) begin
        s_axis_tvalid <= 1'b0;
        while (due_tokens.size() != 0) @(posedge clk);
        paused = 1;
      end
      send_fragment(got);
      items = items + got;
    end

    // last part, no idling: a long identifier, then a comma and a number
    // that ends the stream
    jitter_on = 1'b0;
    send_byte(CH_SPACE, 1'b1, 1'b1);
    for (int i = 0; i < LONG_RUN; i++)
      send_byte(CH_LO_A + 8'(i % 26), 1'b0, 1'b1);
    send_byte(CH_COMMA, 1'b0, 1'b1);
    send_byte(CH_ZERO + 8'd3, 1'b1, 1'b1);

    s_axis_tvalid <= 1'b0;
    while (due_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && due_tokens.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    int down;
    down = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        down     = HOLD_CYCLES;
      end else if (down == 0 && jitter_on && $urandom_range(0, 7) == 0) begin
        down = $urandom_range(1, 10);
      end
      if (down > 0) begin
        down = down - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- checker
  tok_t        want;
  logic [2:0]  got_kind;
  logic [15:0] got_start;
  logic [15:0] got_len;
  logic [4:0]  got_pad;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_kind  = m_axis_tdata[2:0];
      got_start = m_axis_tdata[18:3];
      got_len   = m_axis_tdata[34:19];
      got_pad   = m_axis_tdata[39:35];
      if (due_tokens.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("tb: unexpected token type %0d start %0d len %0d last %0d",
                   got_kind, got_start, got_len, m_axis_tlast);
      end else begin
        want = due_tokens.pop_front();
        if (got_kind != want.kind || got_start != want.start ||
            got_len != want.length || m_axis_tlast != want.last || got_pad != 5'd0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display({"tb: token mismatch: expected type %0d start %0d len %0d last %0d,",
                      " got type %0d start %0d len %0d last %0d pad %0h"},
                     want.kind, want.start, want.length, want.last,
                     got_kind, got_start, got_len, m_axis_tlast, got_pad);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial idle_cycles = 0;

endmodule
